// ===== rtl/core/spc_pkg.sv =====
`default_nettype none
package spc_pkg;

	localparam int MAX_CARS = 1024;
	localparam int CAR_W    = 11;
	localparam int CNT_W    = $clog2(MAX_CARS + 1);
	localparam int NEXT_W   = CAR_W + 1;

	typedef logic [CAR_W-1:0] car_t;

	// one step of the cell chain: push shifts every entry down, pop shifts up
	typedef struct packed {
		logic push;
		logic pop;
		car_t push_val;
	} shift_t;

	// sequence length clamped to 1..MAX_CARS
	function automatic car_t effective_n(car_t len);
		if (len == '0) begin
			return car_t'(1);
		end
		if (32'(len) > 32'(MAX_CARS)) begin
			return car_t'(MAX_CARS);
		end
		return len;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/spc_if.sv =====
`default_nettype none
interface spc_in_if;
	logic             valid;
	logic             ready;
	spc_pkg::car_t    target_car;

	modport source (output valid, output target_car, input ready);
	modport sink   (input valid, input target_car, output ready);
endinterface

interface spc_out_if;
	logic valid;
	logic ready;
	logic popped_ok;
	logic sequence_end;
	logic feasible;

	modport source (output valid, output popped_ok, output sequence_end, output feasible,
		input ready);
	modport sink   (input valid, input popped_ok, input sequence_end, input feasible,
		output ready);
endinterface
`default_nettype wire

// ===== rtl/core/stack_permutation_checker_top.sv =====
`default_nettype none
// Stack permutation checker: each request carries one target car; the block answers
// whether that car could leave the station now and, on the n-th car of a sequence
// (n = cfg_wdata clamped to 1..MAX_CARS), the overall verdict, then starts afresh.
// One request is in flight at a time. A car that is on top of the stack or equals
// the next unpushed car is answered from the evaluate state; a car that needs cars
// pushed first also passes the push state, where the stack, a row of shift cells,
// takes one car per cycle. Each car is pushed at most once per sequence. Results
// sit in an output register, so the next request is taken while a result waits;
// it is then held until that result is taken.
module stack_permutation_checker_top (
	input  wire            clk,
	input  wire            arst_n,
	spc_in_if.sink         car_in,
	spc_out_if.source      result_out,
	input  wire            cfg_we,
	input  spc_pkg::car_t  cfg_wdata
);

	spc_pkg::shift_t shift;
	spc_pkg::car_t   top_val;

	spc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.car_in     (car_in),
		.result_out (result_out),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.top_val    (top_val),
		.shift      (shift)
	);

	spc_stack u_stack (
		.clk     (clk),
		.shift   (shift),
		.top_val (top_val)
	);

endmodule
`default_nettype wire

// ===== rtl/core/spc_cell.sv =====
`default_nettype none
module spc_cell (
	input  wire             clk,
	input  spc_pkg::shift_t shift,
	input  spc_pkg::car_t   up_val,
	input  spc_pkg::car_t   down_val,
	output spc_pkg::car_t   val_q
);

	always_ff @(posedge clk) begin
		if (shift.push) begin
			val_q <= up_val;
		end else if (shift.pop) begin
			val_q <= down_val;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/spc_stack.sv =====
`default_nettype none
module spc_stack (
	input  wire             clk,
	input  spc_pkg::shift_t shift,
	output spc_pkg::car_t   top_val
);

	// cell 0 is the top of the stack; the extra slot feeds the last cell on a pop
	spc_pkg::car_t vals [0:spc_pkg::MAX_CARS];

	assign vals[spc_pkg::MAX_CARS] = '0;

	for (genvar i = 0; i < spc_pkg::MAX_CARS; i++) begin : g_cell
		if (i == 0) begin : g_top
			spc_cell u_cell (
				.clk      (clk),
				.shift    (shift),
				.up_val   (shift.push_val),
				.down_val (vals[i+1]),
				.val_q    (vals[i])
			);
		end else begin : g_body
			spc_cell u_cell (
				.clk      (clk),
				.shift    (shift),
				.up_val   (vals[i-1]),
				.down_val (vals[i+1]),
				.val_q    (vals[i])
			);
		end
	end

	assign top_val = vals[0];

endmodule
`default_nettype wire

// ===== rtl/core/spc_ctrl.sv =====
`default_nettype none
module spc_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	spc_in_if.sink           car_in,
	spc_out_if.source        result_out,
	input  wire              cfg_we,
	input  spc_pkg::car_t    cfg_wdata,
	input  spc_pkg::car_t    top_val,
	output spc_pkg::shift_t  shift
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EVAL = 2'd1;
	localparam logic [1:0] ST_PUSH = 2'd2;

	logic [1:0]                   state_q;
	spc_pkg::car_t                car_q;
	spc_pkg::car_t                len_q;
	logic [spc_pkg::CNT_W-1:0]    count_q;
	logic [spc_pkg::NEXT_W-1:0]   next_q;
	spc_pkg::car_t                pos_q;
	logic                         failed_q;
	logic                         out_valid_q;
	logic                         ok_q;
	logic                         end_q;
	logic                         feas_q;

	spc_pkg::car_t                n;
	logic [spc_pkg::NEXT_W-1:0]   car_ext;
	logic                         out_free;
	logic                         car_bad;
	logic                         top_hit;
	logic                         more_push;
	logic                         full;
	logic                         seq_end;
	logic                         finish;
	logic                         ok;
	logic                         fail_now;
	logic                         do_pop;
	logic                         do_push;
	logic                         go_push;
	logic                         set_next;
	logic                         failed_new;
	logic                         accept;

	assign n         = spc_pkg::effective_n(len_q);
	assign car_ext   = {1'b0, car_q};
	assign out_free  = !out_valid_q || result_out.ready;
	assign car_bad   = (car_q == '0) || (car_q > n);
	assign top_hit   = (count_q != '0) && (top_val == car_q);
	assign more_push = next_q < car_ext;
	assign full      = count_q >= spc_pkg::CNT_W'(spc_pkg::MAX_CARS);
	assign seq_end   = ({1'b0, pos_q} + 1'b1) >= {1'b0, n};
	assign accept    = car_in.valid && car_in.ready;

	always_comb begin
		finish   = 1'b0;
		ok       = 1'b0;
		fail_now = 1'b0;
		do_pop   = 1'b0;
		do_push  = 1'b0;
		go_push  = 1'b0;
		set_next = 1'b0;
		case (state_q)
			ST_EVAL: begin
				if (out_free) begin
					if (failed_q) begin
						finish = 1'b1;
					end else if (car_bad) begin
						fail_now = 1'b1;
						finish   = 1'b1;
					end else if (top_hit) begin
						do_pop = 1'b1;
						ok     = 1'b1;
						finish = 1'b1;
					end else if (car_ext >= next_q) begin
						if (!more_push) begin
							set_next = 1'b1;
							ok       = 1'b1;
							finish   = 1'b1;
						end else if (full) begin
							fail_now = 1'b1;
							finish   = 1'b1;
						end else begin
							do_push = 1'b1;
							go_push = 1'b1;
						end
					end else begin
						fail_now = 1'b1;
						finish   = 1'b1;
					end
				end
			end
			ST_PUSH: begin
				// one car enters the cell chain per cycle until the target is reached
				if (more_push) begin
					if (!full) begin
						do_push = 1'b1;
					end else if (out_free) begin
						fail_now = 1'b1;
						finish   = 1'b1;
					end
				end else if (out_free) begin
					set_next = 1'b1;
					ok       = 1'b1;
					finish   = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign failed_new = failed_q || fail_now;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			len_q       <= spc_pkg::car_t'(1);
			count_q     <= '0;
			next_q      <= spc_pkg::NEXT_W'(1);
			pos_q       <= '0;
			failed_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				len_q <= cfg_wdata;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end else if (go_push) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (do_pop) begin
				count_q <= count_q - 1'b1;
			end else if (do_push) begin
				count_q <= count_q + 1'b1;
				next_q  <= next_q + 1'b1;
			end
			if (set_next) begin
				next_q <= car_ext + 1'b1;
			end
			if (fail_now) begin
				failed_q <= 1'b1;
			end
			if (finish) begin
				if (seq_end) begin
					count_q  <= '0;
					next_q   <= spc_pkg::NEXT_W'(1);
					pos_q    <= '0;
					failed_q <= 1'b0;
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (result_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			car_q <= car_in.target_car;
		end
		if (finish) begin
			ok_q   <= ok;
			end_q  <= seq_end;
			feas_q <= seq_end && !failed_new;
		end
	end

	assign car_in.ready            = (state_q == ST_IDLE);
	assign result_out.valid        = out_valid_q;
	assign result_out.popped_ok    = ok_q;
	assign result_out.sequence_end = end_q;
	assign result_out.feasible     = feas_q;

	assign shift.push     = do_push;
	assign shift.pop      = do_pop;
	assign shift.push_val = next_q[spc_pkg::CAR_W-1:0];

	// fresh sequence: nothing stacked yet
	a_fresh_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && pos_q == '0) |-> (count_q == '0 && next_q == 1 && !failed_q))
		else $error("sequence start with stale stack state");

	// the count of stacked cars stays below the next unpushed car
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) < 32'(next_q))
		else $error("stack count not below next unpushed car");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		do_push |-> !full)
		else $error("push into a full cell chain");

	a_verdict_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && feas_q) |-> end_q)
		else $error("verdict given before sequence end");

	a_pop_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		do_pop |-> (count_q != '0 && !failed_q))
		else $error("pop from empty stack or after failure");

endmodule
`default_nettype wire
